[hdl/lkvt_pkg.sv]
// Package for the linear key-value table: widths, word and cell types,
// operation and status codes, controller states. No dependencies.
package lkvt_pkg;

	// table geometry
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int ENTRY_W  = 6;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3	// unused code: no change, status ok
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_UPD
	} fsm_t;

	// request word
	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_word_t;

	// response word
	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   read_value;
		logic [ENTRY_W-1:0] entry_count;
	} rsp_word_t;

	// contents of one cell
	typedef struct packed {
		logic             occ;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cell_t;

	// per-cell control from the controller
	typedef struct packed {
		logic cmp;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

[hdl/lkvt_cell.sv]
// One entry of the table chain: key, value, occupied flag and match flag.
// Depends on lkvt_pkg.
module lkvt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvt_pkg::cell_ctl_t        ctl,
	input  logic [lkvt_pkg::KEY_W-1:0] key,
	input  logic [lkvt_pkg::VAL_W-1:0] value,
	input  lkvt_pkg::cell_t            nbr,
	output lkvt_pkg::cell_t            cur,
	output logic                       match_q
);

	logic                       occ_q;
	logic [lkvt_pkg::KEY_W-1:0] key_q;
	logic [lkvt_pkg::VAL_W-1:0] value_q;

	// occupied flag: shift from upper neighbor wins over append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift) begin
			occ_q <= nbr.occ;
		end else if (ctl.load) begin
			occ_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q   <= nbr.key;
			value_q <= nbr.value;
		end else if (ctl.load) begin
			key_q   <= key;
			value_q <= value;
		end
	end

	// key compare against the broadcast key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= occ_q && (key_q == key);
		end
	end

	assign cur = '{occ: occ_q, key: key_q, value: value_q};

endmodule

[hdl/lkvt_select.sv]
// Reduces the cells' match flags to found, matching index and stored value.
// Depends on lkvt_pkg.
module lkvt_select (
	input  logic [lkvt_pkg::CAPACITY-1:0] match,
	input  lkvt_pkg::cell_t               cells [lkvt_pkg::CAPACITY],
	output logic                          found,
	output logic [lkvt_pkg::IDX_W-1:0]    idx,
	output logic [lkvt_pkg::VAL_W-1:0]    value
);

	// keys are unique, so at most one flag is set: AND-OR select
	always_comb begin
		idx   = '0;
		value = '0;
		for (int i = 0; i < lkvt_pkg::CAPACITY; i++) begin
			if (match[i]) begin
				idx   = idx | lkvt_pkg::IDX_W'(i);
				value = value | cells[i].value;
			end
		end
	end

	assign found = |match;

endmodule

[hdl/linear_key_value_table.sv]
// Top level of the linear key-value table: controller, cell chain, selector.
// Depends on lkvt_pkg, lkvt_cell, lkvt_select.
//
// The table holds up to CAPACITY key/value pairs packed in a chain of cells,
// one pair per cell. Each request word (put, get, remove) is captured, then
// all occupied cells compare their key against it in parallel, and in the
// update step the match is resolved, the chain is updated (append at the end,
// or the removed cell and every cell above it take the upper neighbor's
// contents) and the response word is written to the output register.
// req_stall is high from acceptance until the update step completes, so a
// new word is not taken before the previous one is through; the update step
// waits while the previous response is still held in the output register.
// Each cell's own occupied flag is cleared at reset; no clearing pass is needed.
module linear_key_value_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  lkvt_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output lkvt_pkg::rsp_word_t rsp
);

	lkvt_pkg::fsm_t                  state_q, state_nxt;
	lkvt_pkg::req_word_t             cmd_s1;
	logic [lkvt_pkg::CNT_W-1:0]      count_q, count_nxt;
	lkvt_pkg::rsp_word_t             rsp_q;
	logic                            rsp_valid_q;
	logic                            accept;
	logic                            upd_fire;

	lkvt_pkg::cell_t                 cells [lkvt_pkg::CAPACITY];
	lkvt_pkg::cell_ctl_t             ctl   [lkvt_pkg::CAPACITY];
	logic [lkvt_pkg::CAPACITY-1:0]   match;
	logic [lkvt_pkg::CAPACITY-1:0]   occ_vec;

	logic                            found;
	logic [lkvt_pkg::IDX_W-1:0]      idx;
	logic [lkvt_pkg::VAL_W-1:0]      sel_value;

	lkvt_pkg::status_t               status;
	logic [lkvt_pkg::VAL_W-1:0]      rd_value;
	logic                            put_ok;
	logic                            rem_ok;

	assign accept = req_valid && !req_stall;

	// controller state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvt_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		upd_fire  = 1'b0;
		unique case (state_q)
			lkvt_pkg::FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_nxt = lkvt_pkg::FSM_CMP;
				end
			end
			lkvt_pkg::FSM_CMP: begin
				state_nxt = lkvt_pkg::FSM_UPD;
			end
			lkvt_pkg::FSM_UPD: begin
				if (!rsp_valid_q || !rsp_stall) begin
					upd_fire  = 1'b1;
					state_nxt = lkvt_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_nxt = lkvt_pkg::FSM_IDLE;
			end
		endcase
	end

	// captured request word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req;
		end
	end

	// cell chain; the top cell shifts in an empty entry
	for (genvar i = 0; i < lkvt_pkg::CAPACITY; i++) begin : g_cell
		lkvt_pkg::cell_t nbr;
		if (i == lkvt_pkg::CAPACITY - 1) begin : g_top
			assign nbr = '{occ: 1'b0, key: '0, value: '0};
		end else begin : g_mid
			assign nbr = cells[i+1];
		end

		assign ctl[i].cmp   = (state_q == lkvt_pkg::FSM_CMP);
		assign ctl[i].load  = upd_fire && put_ok && (count_q == lkvt_pkg::CNT_W'(i));
		assign ctl[i].shift = upd_fire && rem_ok && (lkvt_pkg::IDX_W'(i) >= idx);
		assign occ_vec[i]   = cells[i].occ;

		lkvt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[i]),
			.key     (cmd_s1.key),
			.value   (cmd_s1.value),
			.nbr     (nbr),
			.cur     (cells[i]),
			.match_q (match[i])
		);
	end

	lkvt_select u_select (
		.match (match),
		.cells (cells),
		.found (found),
		.idx   (idx),
		.value (sel_value)
	);

	// decision for the word in the update cycle
	always_comb begin
		status    = lkvt_pkg::ST_OK;
		rd_value  = '0;
		put_ok    = 1'b0;
		rem_ok    = 1'b0;
		count_nxt = count_q;
		unique case (cmd_s1.operation)
			lkvt_pkg::OP_PUT: begin
				if (found) begin
					status = lkvt_pkg::ST_DUP;
				end else if (count_q == lkvt_pkg::CNT_W'(lkvt_pkg::CAPACITY)) begin
					status = lkvt_pkg::ST_FULL;
				end else begin
					put_ok    = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			lkvt_pkg::OP_GET: begin
				if (found) begin
					rd_value = sel_value;
				end else begin
					status = lkvt_pkg::ST_NOT_FOUND;
				end
			end
			lkvt_pkg::OP_REMOVE: begin
				if (found) begin
					rem_ok    = 1'b1;
					count_nxt = count_q - 1'b1;
				end else begin
					status = lkvt_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				// unused code: no change, status ok
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_fire) begin
			count_q <= count_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			rsp_q.status      <= status;
			rsp_q.read_value  <= rd_value;
			rsp_q.entry_count <= lkvt_pkg::ENTRY_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count never passes capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lkvt_pkg::CNT_W'(lkvt_pkg::CAPACITY))
		else $error("entry count above capacity");

	// the number of occupied flags agrees with the count
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == 32'(count_q))
		else $error("occupied cells disagree with count");

	// stored keys are unique: at most one cell matches
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkvt_pkg::FSM_UPD) |-> $onehot0(match))
		else $error("more than one cell matched");

	// a completed remove drops the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && rem_ok) |=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not decrement count");

	// the output register is never overwritten while held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |-> (!rsp_valid_q || !rsp_stall))
		else $error("response overwritten while stalled");

endmodule
